// ----- rtl/tcd_pkg.sv -----
// Shared types and constants for the terminal control code decoder.
// Holds the command codes, the sequence states and the queue word format.
// No dependencies.
`default_nettype none

package tcd_pkg;

   // Display command codes as they leave the block.
   typedef enum logic [4:0] {
      CMD_CHAR         = 5'd0,
      CMD_HOME         = 5'd1,
      CMD_GOTO         = 5'd2,
      CMD_ERASE_LINE   = 5'd3,
      CMD_CLEAR_EOL    = 5'd4,
      CMD_RIGHT        = 5'd5,
      CMD_LEFT         = 5'd6,
      CMD_UP           = 5'd7,
      CMD_DOWN         = 5'd8,
      CMD_CLEAR_EOB    = 5'd9,
      CMD_CLS          = 5'd10,
      CMD_CR           = 5'd11,
      CMD_INS_LINE     = 5'd12,
      CMD_DEL_LINE     = 5'd13,
      CMD_LINEMODE_OFF = 5'd14,
      CMD_LINEMODE_ON  = 5'd15,
      CMD_FG           = 5'd16,
      CMD_BG           = 5'd17,
      CMD_BAD_CODE     = 5'd18,
      CMD_BAD_SELECT   = 5'd19,
      CMD_BAD_CONTROL  = 5'd20
   } cmd_type;

   // Pending multi-byte sequence, one-hot.
   typedef enum logic [8:0] {
      SEQ_IDLE     = 9'b000000001,
      SEQ_GOTO     = 9'b000000010,
      SEQ_SELECT   = 9'b000000100,
      SEQ_LINE_CTL = 9'b000001000,
      SEQ_BG       = 9'b000010000,
      SEQ_BOLD     = 9'b000100000,
      SEQ_FRAME    = 9'b001000000,
      SEQ_FG       = 9'b010000000,
      SEQ_CURS_ARG = 9'b100000000
   } seq_type;

   // Control bytes that lead a sequence or map to a single command.
   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [7:0] BYTE_HOME     = 8'h01;
   localparam logic [7:0] BYTE_GOTO     = 8'h02;
   localparam logic [7:0] BYTE_ERASE    = 8'h03;
   localparam logic [7:0] BYTE_CLEOL    = 8'h04;
   localparam logic [7:0] BYTE_CURSOR   = 8'h05;
   localparam logic [7:0] BYTE_RIGHT    = 8'h06;
   localparam logic [7:0] BYTE_BELL     = 8'h07;
   localparam logic [7:0] BYTE_LEFT     = 8'h08;
   localparam logic [7:0] BYTE_UP       = 8'h09;
   localparam logic [7:0] BYTE_DOWN     = 8'h0A;
   localparam logic [7:0] BYTE_CLEOB    = 8'h0B;
   localparam logic [7:0] BYTE_CLS      = 8'h0C;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_SO       = 8'h0E;
   localparam logic [7:0] BYTE_NAK      = 8'h15;
   localparam logic [7:0] BYTE_ESC      = 8'h1B;
   localparam logic [7:0] BYTE_CTRL     = 8'h1F;
   localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
   localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;
   localparam logic [7:0] BYTE_HIGH     = 8'h80;

   // Selector bytes after ESC.
   localparam logic [7:0] SEL_FG     = 8'h32;
   localparam logic [7:0] SEL_BG     = 8'h33;
   localparam logic [7:0] SEL_BORDER = 8'h34;
   localparam logic [7:0] SEL_BOLD   = 8'h3D;

   // Line control bytes after 0x1F.
   localparam logic [7:0] LC_IGNORE_LO = 8'h20;
   localparam logic [7:0] LC_IGNORE_HI = 8'h25;
   localparam logic [7:0] LC_INS_LINE  = 8'h30;
   localparam logic [7:0] LC_DEL_LINE  = 8'h31;
   localparam logic [7:0] LC_MODE_OFF  = 8'h40;
   localparam logic [7:0] LC_MODE_ON   = 8'h41;

   // Goto coordinates are biased by this amount.
   localparam logic [8:0] COORD_BIAS = 9'd32;

   // Color defaults when the index is out of range.
   localparam logic [3:0] FG_DEFAULT = 4'd15;
   localparam logic [3:0] BG_DEFAULT = 4'd0;
   localparam logic [7:0] COLOR_MAX  = 8'd7;

   localparam logic [31:0] COLOR_MAP_RESET = 32'hBDEC201F;

   // Queue depth and count width.
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One decoded command waiting for the back end.
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;       // current byte
      logic [7:0] first_arg;  // first argument byte of the sequence
   } entry_type;

   // Queue status seen by the top level.
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } qstat_type;

endpackage

`default_nettype wire

// ----- rtl/tcd_front.sv -----
// Front end of the terminal control code decoder: takes bytes, tracks the
// pending sequence and classifies each byte into a queue word.
// Depends on tcd_pkg.
`default_nettype none

module tcd_front (
   input  wire                clock,
   input  wire                reset,
   input  wire                accept,
   input  wire  [7:0]         byte_in,
   output logic               push,
   output tcd_pkg::entry_type entry
);
   import tcd_pkg::*;

   seq_type    seq_ff, seq_in;
   logic       cnt_ff, cnt_in;
   logic [7:0] first_ff, first_in;
   logic       emit;
   cmd_type    cmd;

   // Decode the byte against the pending sequence.
   always_comb begin
      seq_in   = seq_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      emit     = 1'b0;
      cmd      = CMD_CHAR;
      if (seq_ff != SEQ_IDLE) begin
         if (!cnt_ff) begin
            first_in = byte_in;
         end
         if (seq_ff == SEQ_GOTO && !cnt_ff) begin
            cnt_in = 1'b1;
         end else begin
            seq_in = SEQ_IDLE;
            cnt_in = 1'b0;
            unique case (seq_ff)
               SEQ_GOTO: begin
                  emit = 1'b1;
                  cmd  = CMD_GOTO;
               end
               SEQ_SELECT: begin
                  unique case (byte_in)
                     SEL_FG:     seq_in = SEQ_FG;
                     SEL_BG:     seq_in = SEQ_BG;
                     SEL_BORDER: seq_in = SEQ_FRAME;
                     SEL_BOLD:   seq_in = SEQ_BOLD;
                     default: begin
                        emit = 1'b1;
                        cmd  = CMD_BAD_SELECT;
                     end
                  endcase
               end
               SEQ_LINE_CTL: begin
                  priority if (byte_in >= LC_IGNORE_LO && byte_in <= LC_IGNORE_HI) begin
                     emit = 1'b0;
                  end else if (byte_in == LC_INS_LINE) begin
                     emit = 1'b1;
                     cmd  = CMD_INS_LINE;
                  end else if (byte_in == LC_DEL_LINE) begin
                     emit = 1'b1;
                     cmd  = CMD_DEL_LINE;
                  end else if (byte_in == LC_MODE_OFF) begin
                     emit = 1'b1;
                     cmd  = CMD_LINEMODE_OFF;
                  end else if (byte_in == LC_MODE_ON) begin
                     emit = 1'b1;
                     cmd  = CMD_LINEMODE_ON;
                  end else begin
                     emit = 1'b1;
                     cmd  = CMD_BAD_CONTROL;
                  end
               end
               SEQ_FG: begin
                  emit = 1'b1;
                  cmd  = CMD_FG;
               end
               SEQ_BG: begin
                  emit = 1'b1;
                  cmd  = CMD_BG;
               end
               // Border, bold and cursor values are swallowed.
               default: emit = 1'b0;
            endcase
         end
      end else if ((byte_in >= BYTE_PRINT_LO && byte_in <= BYTE_PRINT_HI) ||
                   byte_in > BYTE_HIGH || byte_in == BYTE_BELL) begin
         emit = 1'b1;
         cmd  = CMD_CHAR;
      end else begin
         emit = 1'b1;
         unique case (byte_in)
            BYTE_NUL, BYTE_SO, BYTE_NAK: emit = 1'b0;
            BYTE_HOME:  cmd = CMD_HOME;
            BYTE_GOTO: begin
               emit   = 1'b0;
               seq_in = SEQ_GOTO;
               cnt_in = 1'b0;
            end
            BYTE_ERASE: cmd = CMD_ERASE_LINE;
            BYTE_CLEOL: cmd = CMD_CLEAR_EOL;
            BYTE_CURSOR: begin
               emit   = 1'b0;
               seq_in = SEQ_CURS_ARG;
               cnt_in = 1'b0;
            end
            BYTE_RIGHT: cmd = CMD_RIGHT;
            BYTE_LEFT:  cmd = CMD_LEFT;
            BYTE_UP:    cmd = CMD_UP;
            BYTE_DOWN:  cmd = CMD_DOWN;
            BYTE_CLEOB: cmd = CMD_CLEAR_EOB;
            BYTE_CLS:   cmd = CMD_CLS;
            BYTE_CR:    cmd = CMD_CR;
            BYTE_ESC: begin
               emit   = 1'b0;
               seq_in = SEQ_SELECT;
               cnt_in = 1'b0;
            end
            BYTE_CTRL: begin
               emit   = 1'b0;
               seq_in = SEQ_LINE_CTL;
               cnt_in = 1'b0;
            end
            default:    cmd = CMD_BAD_CODE;
         endcase
      end
   end

   // Sequence state moves only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SEQ_IDLE;
         cnt_ff   <= 1'b0;
         first_ff <= 8'd0;
      end else if (accept) begin
         seq_ff   <= seq_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
      end
   end

   // The goto column comes from the stored first argument.
   assign push            = accept && emit;
   assign entry.cmd       = cmd;
   assign entry.data      = byte_in;
   assign entry.first_arg = first_ff;

endmodule

`default_nettype wire

// ----- rtl/tcd_queue.sv -----
// Two-entry queue between the decoder front end and the back end.
// Depends on tcd_pkg.
`default_nettype none

module tcd_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  wire tcd_pkg::entry_type push_entry,
   input  wire                pop,
   output tcd_pkg::entry_type pop_entry,
   output tcd_pkg::qstat_type stat
);
   import tcd_pkg::*;

   entry_type         mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = wr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = rd_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage words carry no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_entry;
      end
   end

   assign pop_entry  = mem[rd_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ----- rtl/tcd_back.sv -----
// Back end of the terminal control code decoder: formats queued commands,
// maps colors through the color register and holds the output word.
// Depends on tcd_pkg.
`default_nettype none

module tcd_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [31:0]        csr_wr_data,
   input  wire                q_valid,
   input  wire tcd_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               out_valid,
   input  wire                out_ready,
   output logic [4:0]         out_command,
   output logic [7:0]         out_char,
   output logic [8:0]         out_column,
   output logic [8:0]         out_row,
   output logic [3:0]         out_color
);
   import tcd_pkg::*;

   logic [31:0] color_map_ff;
   logic        valid_ff;
   logic [4:0]  command_ff, command_in;
   logic [7:0]  char_ff, char_in;
   logic [8:0]  column_ff, column_in;
   logic [8:0]  row_ff, row_in;
   logic [3:0]  color_ff, color_in;
   logic [3:0]  mapped;

   // Color register; the user must write it only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         color_map_ff <= COLOR_MAP_RESET;
      end else if (csr_wr_en) begin
         color_map_ff <= csr_wr_data;
      end
   end

   // Output register loads when it is empty or being taken.
   assign q_pop = q_valid && (!valid_ff || out_ready);

   assign mapped = color_map_ff[{q_entry.data[2:0], 2'b00} +: 4];

   // Format the fields of the queued command.
   always_comb begin
      command_in = q_entry.cmd;
      char_in    = 8'd0;
      column_in  = 9'd0;
      row_in     = 9'd0;
      color_in   = 4'd0;
      unique case (q_entry.cmd)
         CMD_CHAR, CMD_BAD_CODE, CMD_BAD_SELECT, CMD_BAD_CONTROL: begin
            char_in = q_entry.data;
         end
         CMD_GOTO: begin
            column_in = {1'b0, q_entry.first_arg} - COORD_BIAS;
            row_in    = {1'b0, q_entry.data} - COORD_BIAS;
         end
         CMD_FG: color_in = (q_entry.data > COLOR_MAX) ? FG_DEFAULT : mapped;
         CMD_BG: color_in = (q_entry.data > COLOR_MAX) ? BG_DEFAULT : mapped;
         default: color_in = 4'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         command_ff <= command_in;
         char_ff    <= char_in;
         column_ff  <= column_in;
         row_ff     <= row_in;
         color_ff   <= color_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_command = command_ff;
   assign out_char    = char_ff;
   assign out_column  = column_ff;
   assign out_row     = row_ff;
   assign out_color   = color_ff;

endmodule

`default_nettype wire

// ----- rtl/terminal_control_code_decoder_core.sv -----
// Terminal control code decoder.
// Takes one guest output byte per word on the req_ channel and sends one
// display command word per result on the rsp_ channel.
// req_tdata carries the byte. rsp_tdata carries, from bit 0 up: command
// (5 bits), char_value (8), column (9, signed), row (9, signed), color (4),
// and five zero bits. Bytes inside a multi-byte sequence, and silent codes,
// give no result word.
// The user must write the color register through csr_wr_en and csr_wr_data
// only while the block is idle (not enforced here); reset loads its default map.
// A byte is accepted every cycle while the two-entry queue between the
// decoder front end and the formatting back end has room; a result passes
// through the queue and then the output register on its way to rsp_. The
// sustained rate is one byte per cycle while rsp_tready stays high.
// When the receiver stalls, the output register holds its word, the queue
// fills, and req_tready drops once both queue entries are used.
// Synchronous reset empties the queue and output register, clears any
// pending sequence and restores the color map.
// Depends on tcd_pkg, tcd_front, tcd_queue and tcd_back.
`default_nettype none

module terminal_control_code_decoder_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // byte_in[7:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // command, char_value, column, row, color, pad
   input  wire         csr_wr_en,
   input  wire  [31:0] csr_wr_data
);
   import tcd_pkg::*;

   logic       accept;
   logic       push;
   logic       pop;
   entry_type  push_entry;
   entry_type  pop_entry;
   qstat_type  q_stat;
   logic [4:0] command;
   logic [7:0] char_value;
   logic [8:0] column;
   logic [8:0] row;
   logic [3:0] color;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // Sequence tracking and byte classification.
   tcd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .byte_in (req_tdata),
      .push    (push),
      .entry   (push_entry)
   );

   // Decoupling queue.
   tcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .stat       (q_stat)
   );

   // Formatting and output register.
   tcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (!q_stat.empty),
      .q_entry     (pop_entry),
      .q_pop       (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_command (command),
      .out_char    (char_value),
      .out_column  (column),
      .out_row     (row),
      .out_color   (color)
   );

   assign rsp_tdata = {5'd0, color, row, column, char_value, command};

`ifndef SYNTHESIS
   // The queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // A push with no pop grows the queue by exactly one word.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (q_stat.count == $past(q_stat.count) + QCNT_W'(1)))
      else $error("queue push lost");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // A popped word always lands in the output register.
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_tvalid)
      else $error("popped word not presented");
`endif

endmodule

`default_nettype wire
